[hw/rtl/traffic_phase_decider_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef TRAFFIC_PHASE_DECIDER_MACROS_SVH
`define TRAFFIC_PHASE_DECIDER_MACROS_SVH

`define TPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/tpd_pkg.sv]
package tpd_pkg;

    localparam int unsigned NUM_LANES = 4;

    localparam logic [9:0] SPEED_NORMAL    = 10'd400;
    localparam logic [9:0] SPEED_CONGESTED = 10'd225;

    localparam logic [9:0] RST_CONGESTION_LIMIT  = 10'd15;
    localparam logic [7:0] RST_MIN_GREEN         = 8'd3;
    localparam logic [7:0] RST_BASE_GREEN        = 8'd8;
    localparam logic [7:0] RST_GREEN_CAP         = 8'd45;
    localparam logic [7:0] RST_EMERGENCY_GREEN   = 8'd30;
    localparam logic [3:0] RST_GREEN_PER_VEHICLE = 4'd3;

    typedef enum logic [2:0] {
        CFG_CONGESTION_LIMIT  = 3'd0,
        CFG_MIN_GREEN         = 3'd1,
        CFG_BASE_GREEN        = 3'd2,
        CFG_GREEN_CAP         = 3'd3,
        CFG_EMERGENCY_GREEN   = 3'd4,
        CFG_GREEN_PER_VEHICLE = 3'd5
    } cfg_reg_t;

    typedef logic [1:0] lane_idx_t;

    typedef struct packed {
        logic                emer_hit;
        lane_idx_t           emer_lane;
        lane_idx_t           cur;
        logic [7:0]          t;
        logic [3:0]          moving_zero;
        logic [3:0][7:0]     queued;
        logic [3:0][7:0]     limit;
        logic [9:0]          total;
    } s1_t;

    typedef struct packed {
        logic                emer_hit;
        lane_idx_t           emer_lane;
        logic                startup;
        lane_idx_t           best;
        lane_idx_t           cur;
        logic                due;
        logic [7:0]          dur_hold;
        logic [3:0]          queued_nz;
        logic [3:0][7:0]     limit;
        logic                congested;
    } s2_t;

    typedef struct packed {
        logic [2:0]          green_lane;
        logic [7:0]          green_left;
        logic [9:0]          speed_tenths;
        logic                congested;
    } s3_t;

endpackage

[hw/rtl/tpd_lane_limit.sv]
module tpd_lane_limit (
    input  logic [7:0] queued,
    input  logic [7:0] base_green,
    input  logic [3:0] green_per_vehicle,
    input  logic [7:0] green_cap,
    output logic [7:0] limit
);

    logic [11:0] prod;
    logic [12:0] sum;

    assign prod  = 12'(green_per_vehicle) * 12'(queued);
    assign sum   = 13'(base_green) + 13'(prod);
    assign limit = (sum > 13'(green_cap)) ? green_cap : sum[7:0];

endmodule

[hw/rtl/traffic_phase_decider.sv]
// Four-lane phase decider. One request per cycle is accepted while req_ready
// is high; its result is offered on the result ports after passing through a
// three-stage pipeline (lane limits and queue total, then phase tests and
// busiest-lane pick, then round-robin pick and result register). Back-pressure
// on the result side stalls the pipeline without loss; req_ready drops only
// when all stages hold data and the result is not taken. Registers are written
// through cfg_we/cfg_index/cfg_data and must be changed only while no request
// is in flight.
module traffic_phase_decider (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [7:0] moving_l1,
    input  logic [7:0] moving_l2,
    input  logic [7:0] moving_l3,
    input  logic [7:0] moving_l4,
    input  logic [7:0] queued_l1,
    input  logic [7:0] queued_l2,
    input  logic [7:0] queued_l3,
    input  logic [7:0] queued_l4,
    input  logic [2:0] emergency_lane,
    input  logic [2:0] phase_now,
    input  logic [7:0] phase_age,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [2:0] green_lane,
    output logic [7:0] green_left,
    output logic [9:0] speed_tenths,
    output logic       congested
);

    logic [9:0] congestion_limit_reg;
    logic [7:0] min_green_reg;
    logic [7:0] base_green_reg;
    logic [7:0] green_cap_reg;
    logic [7:0] emergency_green_reg;
    logic [3:0] green_per_vehicle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            congestion_limit_reg  <= tpd_pkg::RST_CONGESTION_LIMIT;
            min_green_reg         <= tpd_pkg::RST_MIN_GREEN;
            base_green_reg        <= tpd_pkg::RST_BASE_GREEN;
            green_cap_reg         <= tpd_pkg::RST_GREEN_CAP;
            emergency_green_reg   <= tpd_pkg::RST_EMERGENCY_GREEN;
            green_per_vehicle_reg <= tpd_pkg::RST_GREEN_PER_VEHICLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpd_pkg::CFG_CONGESTION_LIMIT:  congestion_limit_reg  <= cfg_data;
                tpd_pkg::CFG_MIN_GREEN:         min_green_reg         <= cfg_data[7:0];
                tpd_pkg::CFG_BASE_GREEN:        base_green_reg        <= cfg_data[7:0];
                tpd_pkg::CFG_GREEN_CAP:         green_cap_reg         <= cfg_data[7:0];
                tpd_pkg::CFG_EMERGENCY_GREEN:   emergency_green_reg   <= cfg_data[7:0];
                tpd_pkg::CFG_GREEN_PER_VEHICLE: green_per_vehicle_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic en1, en2, en3;

    assign en3 = !v3_reg || res_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign req_ready = en1;

    assign v1_next = en1 ? req_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // stage 1: lane limits, queue total, field decode
    tpd_pkg::s1_t s1_reg, s1_next;
    logic [3:0][7:0] q_in;
    logic [3:0][7:0] m_in;
    logic [3:0][7:0] lim_in;

    assign q_in = {queued_l4, queued_l3, queued_l2, queued_l1};
    assign m_in = {moving_l4, moving_l3, moving_l2, moving_l1};

    for (genvar g = 0; g < tpd_pkg::NUM_LANES; g++)
    begin : g_lim
        tpd_lane_limit u_lim (
            .queued            (q_in[g]),
            .base_green        (base_green_reg),
            .green_per_vehicle (green_per_vehicle_reg),
            .green_cap         (green_cap_reg),
            .limit             (lim_in[g])
        );
    end

    always_comb
    begin
        s1_next.emer_hit  = (emergency_lane >= 3'd1) && (emergency_lane <= 3'd4);
        s1_next.emer_lane = 2'(emergency_lane - 3'd1);
        s1_next.cur       = ((phase_now >= 3'd1) && (phase_now <= 3'd4))
                          ? 2'(phase_now - 3'd1) : 2'd0;
        s1_next.t         = phase_age;
        for (int i = 0; i < tpd_pkg::NUM_LANES; i++)
        begin
            s1_next.moving_zero[i] = (m_in[i] == 8'd0);
        end
        s1_next.queued = q_in;
        s1_next.limit  = lim_in;
        s1_next.total  = 10'(q_in[0]) + 10'(q_in[1]) + 10'(q_in[2]) + 10'(q_in[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
    end

    // stage 2: phase tests, busiest lane, congestion
    tpd_pkg::s2_t s2_reg, s2_next;
    logic [7:0] cmax;
    logic       early;
    logic       maxed;
    logic [7:0] best_q;

    always_comb
    begin
        cmax  = s1_reg.limit[s1_reg.cur];
        early = (s1_reg.t >= min_green_reg) && s1_reg.moving_zero[s1_reg.cur];
        maxed = (s1_reg.t >= cmax);

        s2_next.best = 2'd0;
        best_q       = s1_reg.queued[0];
        for (int i = 1; i < tpd_pkg::NUM_LANES; i++)
        begin
            if (s1_reg.queued[i] > best_q)
            begin
                s2_next.best = 2'(i);
                best_q       = s1_reg.queued[i];
            end
        end

        s2_next.emer_hit  = s1_reg.emer_hit;
        s2_next.emer_lane = s1_reg.emer_lane;
        s2_next.startup   = (s1_reg.t == 8'd0);
        s2_next.cur       = s1_reg.cur;
        s2_next.due       = early || maxed;
        s2_next.dur_hold  = (cmax > s1_reg.t) ? (cmax - s1_reg.t) : 8'd0;
        for (int i = 0; i < tpd_pkg::NUM_LANES; i++)
        begin
            s2_next.queued_nz[i] = (s1_reg.queued[i] != 8'd0);
        end
        s2_next.limit     = s1_reg.limit;
        s2_next.congested = (s1_reg.total > congestion_limit_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: round-robin pick and final select
    tpd_pkg::s3_t s3_reg, s3_next;
    tpd_pkg::lane_idx_t rr;
    tpd_pkg::lane_idx_t cand;
    tpd_pkg::lane_idx_t sel;
    logic               found;
    logic [7:0]         dur;

    always_comb
    begin
        rr    = s2_reg.cur + 2'd1;
        found = 1'b0;
        for (int k = 1; k <= tpd_pkg::NUM_LANES; k++)
        begin
            cand = s2_reg.cur + 2'(k);
            if (!found && s2_reg.queued_nz[cand])
            begin
                rr    = cand;
                found = 1'b1;
            end
        end

        priority if (s2_reg.emer_hit)
        begin
            sel = s2_reg.emer_lane;
            dur = emergency_green_reg;
        end
        else if (s2_reg.startup)
        begin
            sel = s2_reg.best;
            dur = s2_reg.limit[s2_reg.best];
        end
        else
        begin
            sel = s2_reg.due ? rr : s2_reg.cur;
            dur = (sel != s2_reg.cur) ? s2_reg.limit[sel] : s2_reg.dur_hold;
        end

        s3_next.green_lane   = 3'(sel) + 3'd1;
        s3_next.green_left   = dur;
        s3_next.congested    = s2_reg.congested;
        s3_next.speed_tenths = s2_reg.congested ? tpd_pkg::SPEED_CONGESTED
                                                : tpd_pkg::SPEED_NORMAL;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_reg <= s3_next;
        end
    end

    assign res_valid    = v3_reg;
    assign green_lane   = s3_reg.green_lane;
    assign green_left   = s3_reg.green_left;
    assign speed_tenths = s3_reg.speed_tenths;
    assign congested    = s3_reg.congested;

endmodule

[hw/rtl/tpd_checker.sv]
`include "traffic_phase_decider_macros.svh"

module tpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [2:0] green_lane,
    input logic [7:0] green_left,
    input logic [9:0] speed_tenths,
    input logic       congested
);

    logic        lane_ok;
    logic        speed_ok;
    logic [21:0] res_word;

    assign lane_ok  = (green_lane >= 3'd1) && (green_lane <= 3'd4);
    assign speed_ok = congested ? (speed_tenths == tpd_pkg::SPEED_CONGESTED)
                                : (speed_tenths == tpd_pkg::SPEED_NORMAL);
    assign res_word = {green_lane, green_left, speed_tenths, congested};

    `TPD_ASSERT(a_phase_range, !res_valid || lane_ok, "green lane outside 1..4")

    `TPD_ASSERT(a_speed_match, !res_valid || speed_ok, "speed does not match congestion")

    `TPD_ASSERT(a_ready_when_drained, res_valid || req_ready, "request refused with empty result slot")

    `TPD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word), "stalled result changed")

endmodule

bind traffic_phase_decider tpd_checker u_tpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_ready    (req_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .green_lane   (green_lane),
    .green_left   (green_left),
    .speed_tenths (speed_tenths),
    .congested    (congested)
);
